FILE: hw/rtl/polynomial_term_store_multiply_defines.svh
// Assertion macros for the polynomial term store.
// No dependencies; the including module provides clk and rst_n.
`ifndef POLYNOMIAL_TERM_STORE_MULTIPLY_DEFINES_SVH
`define POLYNOMIAL_TERM_STORE_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PTSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define PTSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ptsm_pkg.sv
// Shared codes and types for the polynomial term store.
// No dependencies; imported by every module of the block.
package ptsm_pkg;

  // Operation codes carried by in_mode
  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_MULT   = 3'd2;
  localparam logic [2:0] MODE_SHOW   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_DUP    = 2'd1;
  localparam logic [1:0] STS_ABSENT = 2'd2;
  localparam logic [1:0] STS_RANGE  = 2'd3;

  // Term store selected for emission
  localparam logic [1:0] SRC_A = 2'd0;
  localparam logic [1:0] SRC_B = 2'd1;
  localparam logic [1:0] SRC_C = 2'd2;

  // Store address width, wide enough for the product store
  localparam int STORE_AW = 6;

  // One command to a term store per cycle
  typedef struct packed {
    logic                wr;   // write coefficient, mark present
    logic                del;  // mark absent
    logic                clr;  // mark all absent
    logic                rd;   // read coefficient into output register
    logic [STORE_AW-1:0] addr;
  } store_cmd_t;

endpackage

FILE: hw/rtl/ptsm_mul.sv
// Coefficient multiplier, low COEF_W bits of the product.
// Depends on ptsm_pkg. Registered multiply up to 32 bits, else three partial products.
module ptsm_mul
  import ptsm_pkg::*;
#(
  parameter int COEF_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [COEF_W-1:0] a,
  input  logic [COEF_W-1:0] b,
  output logic              done,
  output logic [COEF_W-1:0] p
);

  generate
    if (COEF_W <= 32) begin : g_narrow
      logic              done_r;
      logic [COEF_W-1:0] p_r;

      // single registered multiply
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          p_r <= COEF_W'(a * b);
        end
      end

      assign done = done_r;
      assign p    = p_r;
    end else begin : g_wide
      localparam int HW = COEF_W - 32;
      localparam logic [1:0] LAST_STEP = 2'd2;

      logic              busy_r;
      logic              done_r;
      logic [1:0]        step_r;
      logic [COEF_W-1:0] a_r;
      logic [COEF_W-1:0] b_r;
      logic [COEF_W-1:0] acc_r;
      logic [31:0]       mx;
      logic [31:0]       my;
      logic [63:0]       mp;

      // operand pair per step: lo*lo, lo*hi, hi*lo
      always_comb begin
        case (step_r)
          2'd0: begin
            mx = a_r[31:0];
            my = b_r[31:0];
          end
          2'd1: begin
            mx = a_r[31:0];
            my = 32'(b_r[COEF_W-1:32]);
          end
          default: begin
            mx = 32'(a_r[COEF_W-1:32]);
            my = b_r[31:0];
          end
        endcase
      end

      assign mp = {32'b0, mx} * {32'b0, my};

      // step control
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          step_r <= 2'd0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            step_r <= 2'd0;
          end else if (busy_r) begin
            step_r <= step_r + 2'd1;
            if (step_r == LAST_STEP) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      // operands and accumulator; cross terms only reach the high part
      always_ff @(posedge clk) begin
        if (start) begin
          a_r <= a;
          b_r <= b;
        end else if (busy_r) begin
          if (step_r == 2'd0) begin
            acc_r <= COEF_W'(mp);
          end else begin
            acc_r <= acc_r + {mp[HW-1:0], 32'b0};
          end
        end
      end

      assign done = done_r;
      assign p    = acc_r;
    end
  endgenerate

endmodule

FILE: hw/rtl/ptsm_term_store.sv
// One term store: coefficient memory plus presence bits per exponent.
// Depends on ptsm_pkg for the command struct.
module ptsm_term_store
  import ptsm_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int COEF_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  store_cmd_t        cmd,
  input  logic [COEF_W-1:0] wdata,
  output logic [COEF_W-1:0] rd_data,
  output logic [DEPTH-1:0]  present
);

  localparam int AW = $clog2(DEPTH);

  logic [COEF_W-1:0] mem [DEPTH];
  logic [COEF_W-1:0] rd_data_r;
  logic [DEPTH-1:0]  present_r;
  logic [AW-1:0]     addr;

  assign addr = cmd.addr[AW-1:0];

  // coefficient memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  // presence bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (cmd.clr) begin
      present_r <= '0;
    end else if (cmd.wr) begin
      present_r[addr] <= 1'b1;
    end else if (cmd.del) begin
      present_r[addr] <= 1'b0;
    end
  end

  assign rd_data = rd_data_r;
  assign present = present_r;

endmodule

FILE: hw/rtl/polynomial_term_store_multiply.sv
// Polynomial term store with multiply: two operand stores, product store.
// Usage: one input beat per operation on in_*; each operation returns one
// or more beats on out_*, the final one flagged by out_last.
// Add, remove, clear and unused modes: one result beat, registered in the
// cycle after the input beat is taken.
// Show: exponents are scanned from MAX_EXP-1 down and each present term
// is read from the coefficient memory; an empty store gives a single beat
// with out_term_valid low.
// Multiply: an absent A term skips its whole row, an absent B term under a
// present A term is skipped, and each present pair is read (A and B),
// multiplied (C read), then accumulated and written to C; with COEF_WIDTH
// above 32 the multiplier takes three partial products. Then a show of C
// over 2*MAX_EXP-1 exponents follows.
// One operation is worked on at a time; in_stall stays high until its
// last beat is in the output register.
// Reset clears all presence bits at once; coefficient memories are not
// cleared, and their values are used only where a presence bit is set.
// out_stall holds the output register; the block waits for it.
`include "polynomial_term_store_multiply_defines.svh"
module polynomial_term_store_multiply
  import ptsm_pkg::*;
#(
  parameter int MAX_EXP    = 32,
  parameter int COEF_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic               in_which_poly,
  input  logic signed [31:0] in_coef,
  input  logic [4:0]         in_expon,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_term_valid,
  output logic signed [31:0] out_term_coef,
  output logic [5:0]         out_term_expon,
  output logic               out_last
);

  localparam int CD = 2 * MAX_EXP - 1;
  localparam int AW = $clog2(MAX_EXP);
  localparam int CW = $clog2(CD);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MSCAN = 3'd1;
  localparam logic [2:0] ST_MMUL  = 3'd2;
  localparam logic [2:0] ST_MWAIT = 3'd3;
  localparam logic [2:0] ST_ESCAN = 3'd4;
  localparam logic [2:0] ST_EOUT  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic [1:0]    src_r, src_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_term_valid_r, out_term_valid_nxt;
  logic [31:0] out_term_coef_r, out_term_coef_nxt;
  logic [5:0]  out_term_expon_r, out_term_expon_nxt;
  logic        out_last_r, out_last_nxt;

  store_cmd_t cmd_a, cmd_b, cmd_c;
  logic [COEF_WIDTH-1:0] wdata_ab, wdata_c;
  logic [COEF_WIDTH-1:0] rd_a, rd_b, rd_c, rd_sel;
  logic [MAX_EXP-1:0]    pres_a, pres_b, tgt_pres;
  logic [CD-1:0]         pres_c, pres_sel, below_mask;

  logic                  mul_start, mul_done;
  logic [COEF_WIDTH-1:0] mul_p, c_sum;

  logic          in_accept, slot_free;
  logic [AW-1:0] in_idx;
  logic          exp_oor, hit, more_below;
  logic          adv_fin;
  logic [AW-1:0] adv_i, adv_j;
  logic [CW-1:0] s_idx;

  // storage
  ptsm_term_store #(.DEPTH(MAX_EXP), .COEF_W(COEF_WIDTH)) u_store_a (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_a), .wdata(wdata_ab),
    .rd_data(rd_a), .present(pres_a)
  );

  ptsm_term_store #(.DEPTH(MAX_EXP), .COEF_W(COEF_WIDTH)) u_store_b (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_b), .wdata(wdata_ab),
    .rd_data(rd_b), .present(pres_b)
  );

  ptsm_term_store #(.DEPTH(CD), .COEF_W(COEF_WIDTH)) u_store_c (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_c), .wdata(wdata_c),
    .rd_data(rd_c), .present(pres_c)
  );

  ptsm_mul #(.COEF_W(COEF_WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(rd_a), .b(rd_b),
    .done(mul_done), .p(mul_p)
  );

  // handshake
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;

  // add / remove lookup
  assign tgt_pres = in_which_poly ? pres_b : pres_a;
  assign in_idx   = in_expon[AW-1:0];
  assign exp_oor  = {1'b0, in_expon} >= 6'(MAX_EXP);
  assign hit      = tgt_pres[in_idx];
  assign wdata_ab = COEF_WIDTH'(in_coef);

  // next term pair, B index runs fastest, both from the top down
  always_comb begin
    adv_fin = 1'b0;
    adv_i   = i_r;
    adv_j   = j_r;
    if (j_r == '0) begin
      if (i_r == '0) begin
        adv_fin = 1'b1;
      end else begin
        adv_i = i_r - 1'b1;
        adv_j = AW'(MAX_EXP - 1);
      end
    end else begin
      adv_j = j_r - 1'b1;
    end
  end

  // product accumulation into C
  assign s_idx   = CW'(i_r) + CW'(j_r);
  assign c_sum   = pres_c[s_idx] ? (rd_c + mul_p) : mul_p;
  assign wdata_c = c_sum;

  // emission source and last-term detection
  always_comb begin
    case (src_r)
      SRC_A: begin
        pres_sel = CD'(pres_a);
        rd_sel   = rd_a;
      end
      SRC_B: begin
        pres_sel = CD'(pres_b);
        rd_sel   = rd_b;
      end
      default: begin
        pres_sel = pres_c;
        rd_sel   = rd_c;
      end
    endcase
  end

  assign below_mask = (CD'(1) << e_r) - CD'(1);
  assign more_below = |(pres_sel & below_mask);

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    i_nxt              = i_r;
    j_nxt              = j_r;
    e_nxt              = e_r;
    src_nxt            = src_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_status_nxt     = out_status_r;
    out_term_valid_nxt = out_term_valid_r;
    out_term_coef_nxt  = out_term_coef_r;
    out_term_expon_nxt = out_term_expon_r;
    out_last_nxt       = out_last_r;
    cmd_a              = '0;
    cmd_b              = '0;
    cmd_c              = '0;
    mul_start          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        cmd_a.addr = STORE_AW'(in_expon);
        cmd_b.addr = STORE_AW'(in_expon);
        if (in_accept) begin
          // single-beat result unless a scan follows
          out_valid_nxt      = 1'b1;
          out_status_nxt     = STS_OK;
          out_term_valid_nxt = 1'b0;
          out_term_coef_nxt  = '0;
          out_term_expon_nxt = '0;
          out_last_nxt       = 1'b1;
          case (in_mode)
            MODE_ADD: begin
              if (exp_oor) begin
                out_status_nxt = STS_RANGE;
              end else if (hit) begin
                out_status_nxt = STS_DUP;
              end else if (in_which_poly) begin
                cmd_b.wr = 1'b1;
              end else begin
                cmd_a.wr = 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (exp_oor) begin
                out_status_nxt = STS_RANGE;
              end else if (!hit) begin
                out_status_nxt = STS_ABSENT;
              end else if (in_which_poly) begin
                cmd_b.del = 1'b1;
              end else begin
                cmd_a.del = 1'b1;
              end
            end
            MODE_MULT: begin
              out_valid_nxt = 1'b0;
              cmd_c.clr     = 1'b1;
              i_nxt         = AW'(MAX_EXP - 1);
              j_nxt         = AW'(MAX_EXP - 1);
              state_nxt     = ST_MSCAN;
            end
            MODE_SHOW: begin
              out_valid_nxt = 1'b0;
              src_nxt       = in_which_poly ? SRC_B : SRC_A;
              e_nxt         = CW'(MAX_EXP - 1);
              state_nxt     = ST_ESCAN;
            end
            MODE_CLEAR: begin
              if (in_which_poly) begin
                cmd_b.clr = 1'b1;
              end else begin
                cmd_a.clr = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_MSCAN: begin
        cmd_a.addr = STORE_AW'(i_r);
        cmd_b.addr = STORE_AW'(j_r);
        if (!pres_a[i_r]) begin
          // whole row of A absent
          if (i_r == '0) begin
            src_nxt   = SRC_C;
            e_nxt     = CW'(CD - 1);
            state_nxt = ST_ESCAN;
          end else begin
            i_nxt = i_r - 1'b1;
            j_nxt = AW'(MAX_EXP - 1);
          end
        end else if (pres_b[j_r]) begin
          cmd_a.rd  = 1'b1;
          cmd_b.rd  = 1'b1;
          state_nxt = ST_MMUL;
        end else if (adv_fin) begin
          src_nxt   = SRC_C;
          e_nxt     = CW'(CD - 1);
          state_nxt = ST_ESCAN;
        end else begin
          i_nxt = adv_i;
          j_nxt = adv_j;
        end
      end

      ST_MMUL: begin
        mul_start  = 1'b1;
        cmd_c.rd   = 1'b1;
        cmd_c.addr = STORE_AW'(s_idx);
        state_nxt  = ST_MWAIT;
      end

      ST_MWAIT: begin
        cmd_c.addr = STORE_AW'(s_idx);
        if (mul_done) begin
          cmd_c.wr = 1'b1;
          if (adv_fin) begin
            src_nxt   = SRC_C;
            e_nxt     = CW'(CD - 1);
            state_nxt = ST_ESCAN;
          end else begin
            i_nxt     = adv_i;
            j_nxt     = adv_j;
            state_nxt = ST_MSCAN;
          end
        end
      end

      ST_ESCAN: begin
        cmd_a.addr = STORE_AW'(e_r);
        cmd_b.addr = STORE_AW'(e_r);
        cmd_c.addr = STORE_AW'(e_r);
        if (pres_sel[e_r]) begin
          case (src_r)
            SRC_A:   cmd_a.rd = 1'b1;
            SRC_B:   cmd_b.rd = 1'b1;
            default: cmd_c.rd = 1'b1;
          endcase
          state_nxt = ST_EOUT;
        end else if (e_r == '0) begin
          // nothing present at all: one empty beat
          if (slot_free) begin
            out_valid_nxt      = 1'b1;
            out_status_nxt     = STS_OK;
            out_term_valid_nxt = 1'b0;
            out_term_coef_nxt  = '0;
            out_term_expon_nxt = '0;
            out_last_nxt       = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end else begin
          e_nxt = e_r - 1'b1;
        end
      end

      ST_EOUT: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = STS_OK;
          out_term_valid_nxt = 1'b1;
          out_term_coef_nxt  = 32'(rd_sel);
          out_term_expon_nxt = 6'(e_r);
          out_last_nxt       = !more_below;
          if (more_below) begin
            e_nxt     = e_r - 1'b1;
            state_nxt = ST_ESCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      e_r         <= '0;
      src_r       <= SRC_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      e_r         <= e_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r     <= out_status_nxt;
    out_term_valid_r <= out_term_valid_nxt;
    out_term_coef_r  <= out_term_coef_nxt;
    out_term_expon_r <= out_term_expon_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_term_valid = out_term_valid_r;
  assign out_term_coef  = out_term_coef_r;
  assign out_term_expon = out_term_expon_r;
  assign out_last       = out_last_r;

  // checks
  `PTSM_ASSERT_NEXT(a_mult_clears_c, in_accept && (in_mode == MODE_MULT), pres_c == '0, "product store not empty after multiply start")
  `PTSM_ASSERT_IMPL(a_c_write_on_done, cmd_c.wr, (state_r == ST_MWAIT) && mul_done, "product store written without a finished product")
  `PTSM_ASSERT_IMPL(a_emit_present, state_r == ST_EOUT, pres_sel[e_r], "term beat for an absent exponent")

endmodule
